// ----- rtl/ocss_pkg.sv -----
`timescale 1ns / 1ps

package ocss_pkg;

   // Field widths fixed by the transaction format.
   localparam int unsigned MAP_WIDTH    = 32;
   localparam int unsigned SLOT_WIDTH   = 5;
   localparam int unsigned COUNT_WIDTH  = 6;
   localparam int unsigned MODE_WIDTH   = 2;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned CSR_WIDTH    = 6;

   // Default for the top-level slot limit.
   localparam int unsigned OCSS_MAX_SLOTS = 32;

   // Configuration register indexes.
   localparam logic REG_CYCLE_MODE = 1'b0;
   localparam logic REG_SLOT_COUNT = 1'b1;

   // Stepping modes; the reserved code behaves as plain mode.
   localparam logic [MODE_WIDTH-1:0] MODE_PLAIN     = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_CLUSTER   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_POPULATED = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_RESERVED  = 2'd3;

   // Direction codes.
   localparam logic DIR_NEXT = 1'b0;
   localparam logic DIR_PREV = 1'b1;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNCHANGED    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_CHANGED      = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OUT_OF_RANGE = 2'd2;

   typedef struct packed {
      logic                  cmd;
      logic [SLOT_WIDTH-1:0] current_slot;
      logic [MAP_WIDTH-1:0]  occupied_map;
   } req_payload_type;

   typedef struct packed {
      logic [SLOT_WIDTH-1:0]   chosen_slot;
      logic [STATUS_WIDTH-1:0] status;
   } rsp_payload_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic done;
   } dp_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } ctrl_state_type;

endpackage

// ----- rtl/ocss_chan_if.sv -----
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per transaction.
interface ocss_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/ocss_ctrl.sv -----
`timescale 1ns / 1ps

module ocss_ctrl
   import ocss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: take a transaction, scan until the datapath is done, then present it.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dp_status.done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      dp_cmd.load = 1'b0;
      dp_cmd.step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
         end
         ST_SCAN: begin
            dp_cmd.step = !dp_status.done;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/ocss_dpath.sv -----
`timescale 1ns / 1ps

module ocss_dpath
   import ocss_pkg::*;
#(
   parameter int unsigned MAX_SLOTS = OCSS_MAX_SLOTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [CSR_WIDTH-1:0]    csr_wdata,
   input  req_payload_type         req_payload,
   output rsp_payload_type         rsp_payload,
   input  dp_cmd_type              dp_cmd,
   output dp_status_type           dp_status
);

   // Largest usable count: the slot limit, never more than the bitmap width.
   localparam logic [COUNT_WIDTH-1:0] CountCap =
      COUNT_WIDTH'((MAX_SLOTS < MAP_WIDTH) ? MAX_SLOTS : MAP_WIDTH);

   logic [MODE_WIDTH-1:0]  mode_cfg_ff;
   logic [COUNT_WIDTH-1:0] count_cfg_ff;

   logic                   dir_ff;
   logic [MODE_WIDTH-1:0]  mode_ff;
   logic [SLOT_WIDTH-1:0]  cur_ff;
   logic [MAP_WIDTH-1:0]   map_ff;
   logic [COUNT_WIDTH-1:0] n_ff;
   logic [SLOT_WIDTH-1:0]  pos_ff;
   logic [SLOT_WIDTH-1:0]  pos_in;
   logic [SLOT_WIDTH-1:0]  left_ff;
   logic [SLOT_WIDTH-1:0]  left_in;
   logic                   done_ff;
   logic                   done_in;
   logic                   oor_ff;

   logic [COUNT_WIDTH-1:0] n_eff;
   logic [SLOT_WIDTH-1:0]  load_cur;
   logic [MAP_WIDTH-1:0]   load_map;
   logic                   load_oor;
   logic [COUNT_WIDTH-1:0] load_cur_inc;
   logic [SLOT_WIDTH-1:0]  load_cur_dec;
   logic [SLOT_WIDTH-1:0]  pos_inc;
   logic [SLOT_WIDTH-1:0]  pos_dec;
   logic [SLOT_WIDTH-1:0]  pos_wrap;
   logic [COUNT_WIDTH-1:0] pos_inc_wide;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_cfg_ff  <= MODE_PLAIN;
         count_cfg_ff <= 6'd4;
      end else if (csr_we) begin
         case (csr_index)
            REG_CYCLE_MODE: mode_cfg_ff <= csr_wdata[MODE_WIDTH-1:0];
            REG_SLOT_COUNT: count_cfg_ff <= csr_wdata[COUNT_WIDTH-1:0];
            default: mode_cfg_ff <= mode_cfg_ff;
         endcase
      end
   end

   // Effective slot count, clamped to the cap and to at least one slot.
   always_comb begin
      if (count_cfg_ff > CountCap) begin
         n_eff = CountCap;
      end else if (count_cfg_ff == '0) begin
         n_eff = COUNT_WIDTH'(1);
      end else begin
         n_eff = count_cfg_ff;
      end
   end

   assign load_cur     = req_payload.current_slot;
   assign load_map     = req_payload.occupied_map;
   assign load_oor     = {1'b0, load_cur} >= n_eff;
   assign load_cur_inc = {1'b0, load_cur} + COUNT_WIDTH'(1);
   assign load_cur_dec = load_cur - SLOT_WIDTH'(1);

   // Neighbors of the scan position; pos_wrap is the populated-mode step.
   assign pos_inc_wide = {1'b0, pos_ff} + COUNT_WIDTH'(1);
   assign pos_inc      = pos_inc_wide[SLOT_WIDTH-1:0];
   assign pos_dec      = pos_ff - SLOT_WIDTH'(1);

   always_comb begin
      if (dir_ff == DIR_NEXT) begin
         pos_wrap = (pos_inc_wide == n_ff) ? '0 : pos_inc;
      end else begin
         pos_wrap = (pos_ff == '0) ? SLOT_WIDTH'(n_ff - COUNT_WIDTH'(1)) : pos_dec;
      end
   end

   // Scan control: load settles the easy cases at once, step walks one bit per cycle.
   always_comb begin
      pos_in  = pos_ff;
      left_in = left_ff;
      done_in = done_ff;
      if (dp_cmd.load) begin
         pos_in  = load_cur;
         left_in = SLOT_WIDTH'(n_eff - COUNT_WIDTH'(1));
         done_in = 1'b1;
         if (!load_oor) begin
            case (mode_cfg_ff)
               MODE_POPULATED: begin
                  done_in = 1'b0;
               end
               MODE_CLUSTER: begin
                  if (req_payload.cmd == DIR_NEXT) begin
                     if (load_cur_inc < n_eff && load_map[load_cur]) begin
                        pos_in = load_cur_inc[SLOT_WIDTH-1:0];
                     end else begin
                        done_in = 1'b0;
                     end
                  end else begin
                     if (load_cur != '0 && load_map[load_cur_dec]) begin
                        pos_in = load_cur_dec;
                     end else begin
                        done_in = 1'b0;
                     end
                  end
               end
               default: begin
                  if (req_payload.cmd == DIR_NEXT) begin
                     pos_in = (load_cur_inc < n_eff) ? load_cur_inc[SLOT_WIDTH-1:0] : '0;
                  end else begin
                     pos_in = (load_cur != '0) ? load_cur_dec
                                               : SLOT_WIDTH'(n_eff - COUNT_WIDTH'(1));
                  end
               end
            endcase
         end
      end else if (dp_cmd.step && !done_ff) begin
         case (mode_ff)
            MODE_POPULATED: begin
               // Nearest occupied slot in the given direction, wrapping once.
               if (left_ff == '0) begin
                  pos_in  = cur_ff;
                  done_in = 1'b1;
               end else begin
                  pos_in  = pos_wrap;
                  left_in = left_ff - SLOT_WIDTH'(1);
                  done_in = map_ff[pos_wrap];
               end
            end
            MODE_CLUSTER: begin
               // Walk to the edge of the occupied run.
               if (dir_ff == DIR_NEXT) begin
                  if (pos_ff != '0 && map_ff[pos_dec]) begin
                     pos_in = pos_dec;
                  end else begin
                     done_in = 1'b1;
                  end
               end else begin
                  if (pos_inc_wide < n_ff && map_ff[pos_ff]) begin
                     pos_in = pos_inc;
                  end else begin
                     done_in = 1'b1;
                  end
               end
            end
            default: begin
               done_in = 1'b1;
            end
         endcase
      end
   end

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         dir_ff  <= req_payload.cmd;
         mode_ff <= mode_cfg_ff;
         cur_ff  <= load_cur;
         map_ff  <= load_map;
         n_ff    <= n_eff;
         oor_ff  <= load_oor;
      end
   end

   // Scan registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      pos_ff  <= pos_in;
      left_ff <= left_in;
   end

   assign dp_status.done = done_ff;

   // Result fields.
   always_comb begin
      rsp_payload.chosen_slot = pos_ff;
      if (oor_ff) begin
         rsp_payload.status = STATUS_OUT_OF_RANGE;
      end else if (pos_ff != cur_ff) begin
         rsp_payload.status = STATUS_CHANGED;
      end else begin
         rsp_payload.status = STATUS_UNCHANGED;
      end
   end

endmodule

// ----- rtl/occupancy_cyclic_slot_select.sv -----
`timescale 1ns / 1ps
// Populated mode scans up to the effective slot count minus one bitmap bits, then
// closes the scan; cluster mode walks the occupied run.
// One transaction at a time; the next request is taken no earlier than the cycle after
// the response transaction.
// Reset (synchronous, active high) idles the controller, sets cycle_mode to 0 and
// slot_count to 4.

module occupancy_cyclic_slot_select
   import ocss_pkg::*;
#(
   parameter int unsigned MAX_SLOTS = OCSS_MAX_SLOTS
) (
   input  logic                 clock,
   input  logic                 reset,
   ocss_chan_if.sink            req_chan,
   ocss_chan_if.source          rsp_chan,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);

   dp_cmd_type      dp_cmd;
   dp_status_type   dp_status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;

   assign req_payload      = req_chan.payload;
   assign rsp_chan.payload = rsp_payload;

   // Sequencing of transactions.
   ocss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   // Configuration, capture and bit scan.
   ocss_dpath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

endmodule

// ----- rtl/ocss_checker.sv -----
`timescale 1ns / 1ps

module ocss_checker
   import ocss_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [SLOT_WIDTH-1:0]   req_current_slot,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SLOT_WIDTH-1:0]   rsp_chosen_slot,
   input logic [STATUS_WIDTH-1:0] rsp_status
);

   logic                  pending_ff;
   logic [SLOT_WIDTH-1:0] cur_ff;

   // Track the one outstanding transaction and its current slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         pending_ff <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         pending_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         cur_ff <= req_current_slot;
      end
   end

   // A stalled response holds its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chosen_slot) && $stable(rsp_status))
      else $error("response changed while stalled");

   // Every response answers an accepted request.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff)
      else $error("response without a request");

   // No second request while one is outstanding.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> !req_ready)
      else $error("request accepted while busy");

   // Unchanged and out-of-range results return the current slot.
   a_same_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_UNCHANGED || rsp_status == STATUS_OUT_OF_RANGE)
      |-> rsp_chosen_slot == cur_ff)
      else $error("status claims no change but slot moved");

   // A changed result moves away from the current slot.
   a_moved_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CHANGED |-> rsp_chosen_slot != cur_ff)
      else $error("status claims a change but slot stayed");

endmodule

bind occupancy_cyclic_slot_select ocss_checker u_ocss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_current_slot (req_chan.payload.current_slot),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_chosen_slot  (rsp_chan.payload.chosen_slot),
   .rsp_status       (rsp_chan.payload.status)
);
